// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Byte codes, result kinds and controller states shared by the decoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // SLIP special bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Width of the capacity register
  localparam int CAP_W = 7;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OVF,
    S_EMPTY,
    S_READ,
    S_LOAD
  } state_t;

endpackage

`default_nettype wire

// File: rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder channels
// Valid/ready channels for received bytes, decoded results and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic          valid;
  logic          ready;
  sfd_pkg::kind_t kind;
  logic [7:0]    data_byte;
  logic          last;

  modport source (output valid, output kind, output data_byte, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

interface sfd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// File: rtl/sfd_store.sv
// ----------------------------------------------------------------------------
// SLIP message store
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_store #(
  parameter int STORE_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(STORE_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]                     wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(STORE_BYTES)-1:0] rd_addr,
  output logic      [7:0]                     rd_data
);

  logic [7:0] mem [STORE_BYTES];

  // Write one byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// SLIP decoder controller
// Unescapes bytes into the store, detects overflow and replays messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfd_ctrl #(
  parameter int STORE_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [sfd_pkg::CAP_W-1:0]      capacity,
  sfd_in_if.sink                              rx,
  sfd_out_if.source                           res,
  output logic                                wr_en,
  output logic      [$clog2(STORE_BYTES)-1:0] wr_addr,
  output logic      [7:0]                     wr_data,
  output logic                                rd_en,
  output logic      [$clog2(STORE_BYTES)-1:0] rd_addr,
  input  wire logic [7:0]                     rd_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);

  sfd_pkg::state_t state, state_next;

  logic          esc;
  logic          esc_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          pend_empty;
  logic          pend_replay;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_last;

  logic          out_valid;
  sfd_pkg::kind_t out_kind;
  logic [7:0]    out_data;
  logic          out_last;

  logic          accept;
  logic          can_load;
  logic          load;
  sfd_pkg::kind_t load_kind;
  logic [7:0]    eff;
  logic          ovf;
  logic [CW-1:0] fill_c;
  logic          esc_c;
  logic          empty_c;
  logic          replay_c;
  logic [7:0]    b;

  assign b        = rx.rx_byte;
  assign accept   = rx.valid && rx.ready;
  assign can_load = !out_valid || res.ready;

  // Effective capacity saturates at the store size; check free slots
  assign eff    = ({1'b0, capacity} > 8'(STORE_BYTES)) ? 8'(STORE_BYTES)
                                                       : {1'b0, capacity};
  assign ovf    = (8'(fill) + 8'd2) > eff;
  assign fill_c = ovf ? '0 : fill;
  assign esc_c  = ovf ? 1'b0 : esc;

  assign empty_c  = !esc_c && (b == sfd_pkg::SLIP_END) && (fill_c == '0);
  assign replay_c = !esc_c && (b == sfd_pkg::SLIP_END) && (fill_c != '0);

  // Decode the byte: store write, fill and escape update
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = fill_c[AW-1:0];
    wr_data   = b;
    fill_next = fill_c;
    esc_next  = 1'b0;
    priority if (esc_c) begin
      if (b == sfd_pkg::SLIP_ESC_END) begin
        wr_en     = 1'b1;
        wr_data   = sfd_pkg::SLIP_END;
        fill_next = fill_c + CW'(1);
      end else if (b == sfd_pkg::SLIP_ESC_ESC) begin
        wr_en     = 1'b1;
        wr_data   = sfd_pkg::SLIP_ESC;
        fill_next = fill_c + CW'(1);
      end else begin
        fill_next = '0;
      end
    end else if (b == sfd_pkg::SLIP_END) begin
      fill_next = '0;
    end else if (b == sfd_pkg::SLIP_ESC) begin
      esc_next = 1'b1;
    end else begin
      wr_en     = 1'b1;
      fill_next = fill_c + CW'(1);
    end
    wr_en = wr_en && accept;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfd_pkg::S_IDLE: begin
        if (accept) begin
          priority if (ovf)      state_next = sfd_pkg::S_OVF;
          else if (empty_c)      state_next = sfd_pkg::S_EMPTY;
          else if (replay_c)     state_next = sfd_pkg::S_READ;
          else                   state_next = sfd_pkg::S_IDLE;
        end
      end
      sfd_pkg::S_OVF: begin
        if (can_load) begin
          priority if (pend_empty) state_next = sfd_pkg::S_EMPTY;
          else if (pend_replay)    state_next = sfd_pkg::S_READ;
          else                     state_next = sfd_pkg::S_IDLE;
        end
      end
      sfd_pkg::S_EMPTY: begin
        if (can_load) state_next = sfd_pkg::S_IDLE;
      end
      sfd_pkg::S_READ: begin
        state_next = sfd_pkg::S_LOAD;
      end
      sfd_pkg::S_LOAD: begin
        if (can_load) begin
          state_next = (rd_idx == rd_last) ? sfd_pkg::S_IDLE : sfd_pkg::S_READ;
        end
      end
      default: state_next = sfd_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    rx.ready  = 1'b0;
    load      = 1'b0;
    load_kind = sfd_pkg::KIND_BYTE;
    rd_en     = 1'b0;
    unique case (state)
      sfd_pkg::S_IDLE: begin
        rx.ready = 1'b1;
      end
      sfd_pkg::S_OVF: begin
        load      = can_load;
        load_kind = sfd_pkg::KIND_OVERFLOW;
      end
      sfd_pkg::S_EMPTY: begin
        load      = can_load;
        load_kind = sfd_pkg::KIND_EMPTY;
      end
      sfd_pkg::S_READ: begin
        rd_en = 1'b1;
      end
      sfd_pkg::S_LOAD: begin
        load = can_load;
      end
      default: begin
        rx.ready = 1'b0;
      end
    endcase
  end

  assign rd_addr = rd_idx;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::S_IDLE;
      fill  <= '0;
      esc   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= fill_next;
        esc  <= esc_next;
      end
    end
  end

  // Capture what the accepted byte still owes
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_empty  <= empty_c;
      pend_replay <= replay_c;
      rd_idx      <= '0;
      rd_last     <= AW'(fill_c - CW'(1));
    end else if (state == sfd_pkg::S_LOAD && can_load) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  // Output register: load a beat, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= load_kind;
      if (load_kind == sfd_pkg::KIND_BYTE) begin
        out_data <= rd_data;
        out_last <= (rd_idx == rd_last);
      end else begin
        out_data <= 8'd0;
        out_last <= 1'b1;
      end
    end
  end

  assign res.valid     = out_valid;
  assign res.kind      = out_kind;
  assign res.data_byte = out_data;
  assign res.last      = out_last;

endmodule

`default_nettype wire

// File: rtl/slip_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Decodes a SLIP byte stream into message bytes, empty and overflow events.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one raw SLIP byte per beat (valid/ready).
//   res : result beats {kind, data_byte, last}; kind is message byte,
//         empty message or overflow. last marks the final byte of a message
//         and is set on every event beat.
//   cfg : write beat of the capacity register; always ready. Write only
//         while the decoder is idle.
//   An END that replays stored bytes is accepted first; then each byte is
//   read from the store and then loaded into the output register. Each
//   event beat is loaded into the output register from its own state
//   after its byte is accepted.
//   rx.ready is high only while the controller is idle, so one byte is in
//   work at a time; the output register lets the next byte enter while the
//   last result still waits. A stalled res holds the controller in place.
//   Reset clears the fill count, the escape flag and the output valid, and
//   sets capacity to 64. The store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slip_frame_decoder_top #(
  parameter int STORE_BYTES = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  sfd_in_if.sink    rx,
  sfd_out_if.source res,
  sfd_cfg_if.sink   cfg
);

  localparam int AW = $clog2(STORE_BYTES);

  logic [sfd_pkg::CAP_W-1:0] capacity;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [7:0]                wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [7:0]                rd_data;

  // Capacity register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sfd_pkg::CAP_W'(64);
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.capacity;
    end
  end

  sfd_ctrl #(
    .STORE_BYTES (STORE_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .rx       (rx),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  sfd_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: tb/sv/slip_frame_decoder_checker.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder checker
// Watches the byte, result and capacity channels, decodes every accepted
// byte beat into the result beats it must cause, and compares each accepted
// result beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slip_frame_decoder_checker #(
  parameter int STORE_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  sfd_in_if    rx,
  sfd_out_if   res,
  sfd_cfg_if   cfg,
  output int   error_count,
  output int   results_pending
);

  import sfd_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last;
  } slip_result_t;

  slip_result_t     expected_results [$];
  logic [CAP_W-1:0] capacity;
  logic             escape_pending;
  int               fill_count;
  logic [7:0]       message_store [STORE_BYTES];

  function automatic void queue_result(input kind_t k, input logic [7:0] d, input logic l);
    slip_result_t r;
    r.kind      = k;
    r.data_byte = d;
    r.last      = l;
    expected_results.push_back(r);
  endfunction

  function automatic void drop_message();
    fill_count     = 0;
    escape_pending = 1'b0;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    if (fill_count < STORE_BYTES) begin
      message_store[fill_count] = b;
      fill_count++;
    end
  endfunction

  // Decode one received byte and queue the result beats it causes
  function automatic void decode_rx_byte(input logic [7:0] b);
    int usable;
    usable = (int'(capacity) > STORE_BYTES) ? STORE_BYTES : int'(capacity);
    // Report overflow and drop the message before handling the byte
    if (fill_count + 2 > usable) begin
      queue_result(KIND_OVERFLOW, 8'h00, 1'b1);
      drop_message();
    end
    if (escape_pending) begin
      if (b == SLIP_ESC_END) begin
        store_byte(SLIP_END);
      end else if (b == SLIP_ESC_ESC) begin
        store_byte(SLIP_ESC);
      end else begin
        drop_message();
      end
      escape_pending = 1'b0;
    end else if (b == SLIP_END) begin
      // Replay the stored message, or flag an empty one
      if (fill_count == 0) begin
        queue_result(KIND_EMPTY, 8'h00, 1'b1);
      end else begin
        for (int i = 0; i < fill_count; i++) begin
          queue_result(KIND_BYTE, message_store[i], (i + 1 == fill_count));
        end
      end
      drop_message();
    end else if (b == SLIP_ESC) begin
      escape_pending = 1'b1;
    end else begin
      store_byte(b);
    end
  endfunction

  // Compare result beats, then advance the decoder state on byte and write beats
  always @(posedge clk) begin
    slip_result_t want;
    int           new_errors;
    new_errors = 0;
    if (rst) begin
      capacity       = 7'd64;
      escape_pending = 1'b0;
      fill_count     = 0;
      expected_results.delete();
      error_count     <= 0;
      results_pending <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: kind %0d data_byte 0x%02h last %0b",
                 res.kind, res.data_byte, res.last);
          new_errors++;
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, res.kind);
            new_errors++;
          end
          if (res.data_byte !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, res.data_byte);
            new_errors++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, res.last);
            new_errors++;
          end
        end
      end
      if (rx.valid && rx.ready) begin
        decode_rx_byte(rx.rx_byte);
      end
      if (cfg.valid && cfg.ready) begin
        capacity = cfg.capacity;
      end
      error_count     <= error_count + new_errors;
      results_pending <= expected_results.size();
    end
  end

endmodule

// File: tb/sv/slip_frame_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder testbench
// Feeds directed frames (empty frame, byte extremes, both escapes, broken
// escapes, overflow with a pending escape, capacity lowered mid-message),
// then random well-formed frames mixed with noise across a sweep of
// capacities, with bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slip_frame_decoder_top_tb;

  import sfd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int STORE_BYTES   = 64;
  localparam int RANDOM_ITEMS  = 170;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_BURSTY
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_in_if  rx_ch ();
  sfd_out_if res_ch ();
  sfd_cfg_if cfg_ch ();

  int error_count;
  int results_pending;
  int cycle_count = 0;
  int hold_seq = 0;
  int rx_beats = 0;
  int burst_left = 0;

  logic [CAP_W-1:0] cap_sweep [12];

  slip_frame_decoder_top #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  slip_frame_decoder_checker #(
    .STORE_BYTES(STORE_BYTES)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx_ch),
    .res            (res_ch),
    .cfg            (cfg_ch),
    .error_count    (error_count),
    .results_pending(results_pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL slip_frame_decoder_top");
      $finish;
    end
  end

  // Stall the result channel on a changing pattern; hold off on request
  initial begin
    int          hold_left;
    int          stall_left;
    int          mode_left;
    int          hold_seen;
    ready_mode_t ready_mode;
    hold_left    = 0;
    stall_left   = 0;
    mode_left    = 0;
    hold_seen    = 0;
    ready_mode   = RDY_ALWAYS;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          RDY_ALWAYS: begin
            res_ch.ready <= 1'b1;
          end
          RDY_COIN: begin
            res_ch.ready <= 1'($urandom_range(0, 1));
          end
          RDY_PERIODIC: begin
            res_ch.ready <= (mode_left % 3 != 0);
          end
          default: begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 7);
          end
        endcase
      end
    end
  end

  // Send one byte beat; open a new burst after a random gap when one runs out
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    rx_beats++;
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Send a well-formed frame of random content, escaping END and ESC
  task automatic send_frame(input int len);
    logic [7:0] d;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        d = SLIP_END;
      end else if (pick == 1) begin
        d = SLIP_ESC;
      end else begin
        d = 8'($urandom_range(0, 255));
      end
      if (d == SLIP_END) begin
        send_byte(SLIP_ESC);
        send_byte(SLIP_ESC_END);
      end else if (d == SLIP_ESC) begin
        send_byte(SLIP_ESC);
        send_byte(SLIP_ESC_ESC);
      end else begin
        send_byte(d);
      end
    end
    send_byte(SLIP_END);
  endtask

  // Send noise: a raw byte, an escape with any follower, or a bare END
  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick == 2) begin
      send_byte(SLIP_ESC);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(SLIP_END);
    end
  endtask

  // Drop valid and wait until every predicted beat has arrived and the block settles
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] seq [$];
    int         start;
    int         next_cfg_at;
    int         phase;
    int         pick;
    bit         hold_done;
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = 8'h00;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = '0;
    cap_sweep = '{7'd127, 7'd4, 7'd0, 7'd16, 7'd1, 7'd64,
                  7'd2, 7'd65, 7'd3, 7'd32, 7'd5, 7'd63};
    hold_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty frame, byte extremes and both escape pairs
    seq = '{SLIP_END, 8'h00, 8'hFF, SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC, SLIP_END};
    send_bytes(seq);
    // Broken escape drops the partial message
    seq = '{8'h5A, SLIP_ESC, 8'h41, 8'h12, SLIP_END};
    send_bytes(seq);
    // ESC before END or before ESC drops too, so the final END is empty
    seq = '{8'h33, SLIP_ESC, SLIP_END, SLIP_ESC, SLIP_ESC, SLIP_END};
    send_bytes(seq);
    // Lower the capacity to the fill level mid-message
    seq = '{8'h01, 8'h02, 8'h03, 8'h04};
    send_bytes(seq);
    write_capacity(7'd4);
    seq = '{8'h05, SLIP_END};
    send_bytes(seq);
    // Zero capacity: overflow on every byte, pending ESC forgotten, overflow then empty
    write_capacity(7'd0);
    seq = '{8'h7E, SLIP_ESC, SLIP_ESC_END, SLIP_END};
    send_bytes(seq);

    // Random frames and noise over a sweep of capacities
    start       = rx_beats;
    next_cfg_at = 0;
    phase       = 0;
    while (rx_beats - start < RANDOM_ITEMS) begin
      if (rx_beats - start >= next_cfg_at) begin
        write_capacity(cap_sweep[phase % 12]);
        phase++;
        next_cfg_at += $urandom_range(12, 30);
      end
      // Hold off the receiver once while bytes keep coming
      if (!hold_done && rx_beats - start >= RANDOM_ITEMS / 2) begin
        hold_seq  <= hold_seq + 1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        send_frame($urandom_range(0, 6));
      end else if (pick < 14) begin
        send_frame($urandom_range(7, 24));
      end else if (pick == 14) begin
        send_frame($urandom_range(25, 70));
      end else begin
        send_noise();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS slip_frame_decoder_top");
    end else begin
      $display("FAIL slip_frame_decoder_top");
    end
    $finish;
  end

endmodule
